// ===== design/mi3_pkg.sv =====
// Package for the 3x3 fixed-point matrix inverse: widths, types and cofactor tables.
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

   // Default fraction bits of the Q format
   localparam int FRAC_BITS_DEF = 16;

   // Entry and arithmetic widths
   localparam int ENTRY_W  = 32;
   localparam int N_ENTRY  = 9;
   localparam int N_PROD   = 18;
   localparam int PROD_W   = 2 * ENTRY_W;
   localparam int COF_W    = 2 * ENTRY_W;
   localparam int DET_W    = COF_W + ENTRY_W + 2;
   localparam int DMAG_W   = DET_W - 1;
   localparam int QUO_W    = ENTRY_W + 1;
   localparam int REM_W    = DMAG_W + QUO_W;
   localparam int IDX_W    = 4;

   // Port widths
   localparam int REQ_DATA_W = N_ENTRY * ENTRY_W;
   localparam int RSP_DATA_W = N_ENTRY * ENTRY_W;
   localparam int RSP_USER_W = 2;

   // Flag positions in the response tuser
   localparam int USER_SINGULAR  = 0;
   localparam int USER_SATURATED = 1;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [COF_W-1:0]   cof_type;
   typedef logic signed [DET_W-1:0]   det_type;
   typedef logic [IDX_W-1:0]          idx_type;

   // Entry index pairs of the products; cofactor k = prod[2k] - prod[2k+1]
   // Entries: a00=0 a01=1 a02=2 a10=3 a11=4 a12=5 a20=6 a21=7 a22=8
   localparam idx_type MUL_L [N_PROD] = '{
      4'd4, 4'd5,  4'd5, 4'd3,  4'd3, 4'd4,
      4'd2, 4'd1,  4'd0, 4'd2,  4'd1, 4'd0,
      4'd1, 4'd2,  4'd2, 4'd0,  4'd0, 4'd1
   };
   localparam idx_type MUL_R [N_PROD] = '{
      4'd8, 4'd7,  4'd6, 4'd8,  4'd7, 4'd6,
      4'd7, 4'd8,  4'd8, 4'd6,  4'd6, 4'd7,
      4'd5, 4'd4,  4'd3, 4'd5,  4'd4, 4'd3
   };

   // Result entry (i,j) takes cofactor (j,i)
   localparam idx_type TRANS [N_ENTRY] = '{
      4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8
   };

endpackage

`default_nettype wire

// ===== design/matrix3_inverse_core.sv =====
// 3x3 signed fixed-point matrix inverse by adjugate over determinant, fully pipelined.
// Pipeline: the arithmetic stages, the division setup stage, 33 restoring-division stages
//    and one output register, from req transaction to rsp valid.
// Throughput: one matrix per cycle; a stalled rsp side freezes the whole pipeline.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module matrix3_inverse_core #(
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // a00, a01, a02, a10, a11, a12, a20, a21, a22 (32 bits each)
   input  wire logic [mi3_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // r00, r01, r02, r10, r11, r12, r20, r21, r22 (32 bits each)
   output logic [mi3_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // singular, saturated
   output logic [mi3_pkg::RSP_USER_W-1:0]       rsp_tuser
);

   import mi3_pkg::*;

   localparam int NUM_SH = 2 * FRAC_BITS;
   localparam int DIV_N  = QUO_W;

   logic adv;

   // stage 1: products
   entry_type a_in [N_ENTRY];
   prod_type  prod_in [N_PROD];
   prod_type  prod_ff [N_PROD];
   entry_type r0_ff   [3];
   logic      v1_ff;

   // stage 2: cofactors
   cof_type   cof_in  [N_ENTRY];
   cof_type   cof2_ff [N_ENTRY];
   entry_type r0b_ff  [3];
   logic      v2_ff;

   // stage 3: determinant partial products
   logic signed [PROD_W-1:0] hi_in [3];
   logic signed [PROD_W:0]   lo_in [3];
   logic signed [PROD_W-1:0] hi_ff [3];
   logic signed [PROD_W:0]   lo_ff [3];
   cof_type   cof3_ff [N_ENTRY];
   logic      v3_ff;

   // stage 4: determinant terms
   det_type   term_in [3];
   det_type   term_ff [3];
   cof_type   cof4_ff [N_ENTRY];
   logic      v4_ff;

   // stage 5: determinant
   det_type   det_in;
   det_type   det_ff;
   cof_type   cof5_ff [N_ENTRY];
   logic      v5_ff;

   // stage 6: magnitudes and signs
   logic [DMAG_W-1:0] dmag_in;
   logic [DMAG_W-1:0] dmag_ff;
   logic [COF_W-1:0]  cmag_in [N_ENTRY];
   logic [COF_W-1:0]  cmag_ff [N_ENTRY];
   logic [N_ENTRY-1:0] neg_in;
   logic [N_ENTRY-1:0] neg_ff;
   logic               sing_in;
   logic               sing_ff;
   logic               v6_ff;

   // division pipeline; index 0 is the setup stage
   logic [REM_W-1:0]   rem_in  [DIV_N+1][N_ENTRY];
   logic [QUO_W-1:0]   quo_in  [DIV_N+1][N_ENTRY];
   logic [N_ENTRY-1:0] ovf_in;
   logic [REM_W-1:0]   rem_ff  [DIV_N+1][N_ENTRY];
   logic [QUO_W-1:0]   quo_ff  [DIV_N+1][N_ENTRY];
   logic [DMAG_W-1:0]  ddiv_ff [DIV_N+1];
   logic [N_ENTRY-1:0] dneg_ff [DIV_N+1];
   logic [N_ENTRY-1:0] dovf_ff [DIV_N+1];
   logic [DIV_N:0]     dsing_ff;
   logic [DIV_N:0]     dvld_ff;

   // output register
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_in;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic                  rsp_valid_ff;

   // advance the whole pipeline unless the held result is refused
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // unpack the matrix and form the cofactor products
   always_comb begin
      for (int e = 0; e < N_ENTRY; e++) begin
         a_in[e] = entry_type'(req_tdata[e*ENTRY_W +: ENTRY_W]);
      end
      for (int p = 0; p < N_PROD; p++) begin
         prod_in[p] = prod_type'(a_in[MUL_L[p]]) * prod_type'(a_in[MUL_R[p]]);
      end
   end

   // cofactors as exact differences
   always_comb begin
      for (int k = 0; k < N_ENTRY; k++) begin
         cof_in[k] = prod_ff[2*k] - prod_ff[2*k+1];
      end
   end

   // split first-row cofactors into 32-bit halves times the first-row entries
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hi_in[k] = prod_type'(entry_type'(cof2_ff[k][COF_W-1:ENTRY_W])) *
                    prod_type'(r0b_ff[k]);
         lo_in[k] = $signed({1'b0, cof2_ff[k][ENTRY_W-1:0]}) *
                    (PROD_W+1)'(r0b_ff[k]);
      end
   end

   // recombine the halves into full terms
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term_in[k] = (det_type'(hi_ff[k]) <<< ENTRY_W) + det_type'(lo_ff[k]);
      end
   end

   // sum the determinant
   assign det_in = term_ff[0] + term_ff[1] + term_ff[2];

   // take magnitudes and result signs; lane e uses the transposed cofactor
   always_comb begin
      det_type dabs;
      dabs    = det_ff[DET_W-1] ? -det_ff : det_ff;
      dmag_in = dabs[DMAG_W-1:0];
      sing_in = (det_ff == '0);
      for (int e = 0; e < N_ENTRY; e++) begin
         cmag_in[e] = cof5_ff[TRANS[e]][COF_W-1] ? (~cof5_ff[TRANS[e]] + 1'b1)
                                                 : cof5_ff[TRANS[e]];
         neg_in[e]  = cof5_ff[TRANS[e]][COF_W-1] ^ det_ff[DET_W-1];
      end
   end

   // set up the numerators and the overflow check, then one quotient bit a stage
   always_comb begin
      for (int e = 0; e < N_ENTRY; e++) begin
         rem_in[0][e] = REM_W'(cmag_ff[e]) << NUM_SH;
         quo_in[0][e] = '0;
         ovf_in[e]    = rem_in[0][e] >= (REM_W'(dmag_ff) << QUO_W);
      end
      for (int s = 1; s <= DIV_N; s++) begin
         for (int e = 0; e < N_ENTRY; e++) begin
            logic [REM_W-1:0] dsh;
            dsh = REM_W'(ddiv_ff[s-1]) << (DIV_N - s);
            if (rem_ff[s-1][e] >= dsh) begin
               rem_in[s][e] = rem_ff[s-1][e] - dsh;
               quo_in[s][e] = {quo_ff[s-1][e][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[s][e] = rem_ff[s-1][e];
               quo_in[s][e] = {quo_ff[s-1][e][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   // saturate, apply sign, and clear everything for a singular matrix
   always_comb begin
      logic any_sat;
      any_sat = 1'b0;
      for (int e = 0; e < N_ENTRY; e++) begin
         logic [QUO_W-1:0] q;
         logic [QUO_W-1:0] lim;
         logic             neg;
         logic             sat;
         q   = quo_ff[DIV_N][e];
         neg = dneg_ff[DIV_N][e];
         lim = neg ? (QUO_W'(1) << (ENTRY_W-1)) : ((QUO_W'(1) << (ENTRY_W-1)) - 1'b1);
         sat = dovf_ff[DIV_N][e] || (q > lim);
         if (dsing_ff[DIV_N]) begin
            rsp_data_in[e*ENTRY_W +: ENTRY_W] = '0;
         end else if (sat) begin
            rsp_data_in[e*ENTRY_W +: ENTRY_W] = neg ? {1'b1, {(ENTRY_W-1){1'b0}}}
                                                    : {1'b0, {(ENTRY_W-1){1'b1}}};
         end else begin
            rsp_data_in[e*ENTRY_W +: ENTRY_W] = neg ? (~q[ENTRY_W-1:0] + 1'b1)
                                                    : q[ENTRY_W-1:0];
         end
         any_sat = any_sat | sat;
      end
      rsp_user_in[USER_SINGULAR]  = dsing_ff[DIV_N];
      rsp_user_in[USER_SATURATED] = any_sat & ~dsing_ff[DIV_N];
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         dvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_tvalid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         dvld_ff      <= {dvld_ff[DIV_N-1:0], v6_ff};
         rsp_valid_ff <= dvld_ff[DIV_N];
      end
   end

   // advance the arithmetic stages
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < N_PROD; p++) begin
            prod_ff[p] <= prod_in[p];
         end
         for (int k = 0; k < 3; k++) begin
            r0_ff[k]   <= a_in[k];
            r0b_ff[k]  <= r0_ff[k];
            hi_ff[k]   <= hi_in[k];
            lo_ff[k]   <= lo_in[k];
            term_ff[k] <= term_in[k];
         end
         for (int k = 0; k < N_ENTRY; k++) begin
            cof2_ff[k] <= cof_in[k];
            cof3_ff[k] <= cof2_ff[k];
            cof4_ff[k] <= cof3_ff[k];
            cof5_ff[k] <= cof4_ff[k];
            cmag_ff[k] <= cmag_in[k];
         end
         det_ff  <= det_in;
         dmag_ff <= dmag_in;
         neg_ff  <= neg_in;
         sing_ff <= sing_in;
      end
   end

   // advance the division stages and the output register
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < N_ENTRY; e++) begin
            rem_ff[0][e] <= rem_in[0][e];
            quo_ff[0][e] <= quo_in[0][e];
         end
         ddiv_ff[0]  <= dmag_ff;
         dneg_ff[0]  <= neg_ff;
         dovf_ff[0]  <= ovf_in;
         dsing_ff[0] <= sing_ff;
         for (int s = 1; s <= DIV_N; s++) begin
            for (int e = 0; e < N_ENTRY; e++) begin
               rem_ff[s][e] <= rem_in[s][e];
               quo_ff[s][e] <= quo_in[s][e];
            end
            ddiv_ff[s]  <= ddiv_ff[s-1];
            dneg_ff[s]  <= dneg_ff[s-1];
            dovf_ff[s]  <= dovf_ff[s-1];
            dsing_ff[s] <= dsing_ff[s-1];
         end
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== tb/matrix3_inverse_core_test.sv =====
// Testbench for the 3x3 fixed-point matrix inverse: random and directed matrices, self-checking.
`timescale 1ns / 1ps
`default_nettype none

module matrix3_inverse_core_test;
   import mi3_pkg::*;

   localparam int FRAC     = FRAC_BITS_DEF;
   localparam int LATENCY  = 41;
   localparam int N_RANDOM = 750;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [RSP_DATA_W-1:0] entries;
      logic                  singular;
      logic                  saturated;
   } inverse_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   logic [REQ_DATA_W-1:0] pending_matrices[$];
   inverse_type           expected_inverses[$];
   logic   stimulus_done = 1'b0;
   logic   hold_sender = 1'b0;
   logic   paused_once = 1'b0;
   int     mismatches = 0;
   int     checked = 0;
   int     singular_seen = 0;
   int     saturated_seen = 0;
   longint cycle = 0;

   matrix3_inverse_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #1 clock = ~clock;

   // Compute the inverse as adjugate over determinant, exact until one truncating divide
   function automatic inverse_type predict_inverse(logic [REQ_DATA_W-1:0] m);
      logic signed [31:0]  a[9];
      logic signed [63:0]  cof[9];
      logic signed [127:0] det;
      logic signed [127:0] num;
      logic signed [127:0] quo;
      inverse_type res;
      res = '0;
      for (int k = 0; k < 9; k++) a[k] = m[k*32 +: 32];
      cof[0] = 64'(a[4]) * a[8] - 64'(a[5]) * a[7];
      cof[1] = 64'(a[5]) * a[6] - 64'(a[3]) * a[8];
      cof[2] = 64'(a[3]) * a[7] - 64'(a[4]) * a[6];
      cof[3] = 64'(a[2]) * a[7] - 64'(a[1]) * a[8];
      cof[4] = 64'(a[0]) * a[8] - 64'(a[2]) * a[6];
      cof[5] = 64'(a[1]) * a[6] - 64'(a[0]) * a[7];
      cof[6] = 64'(a[1]) * a[5] - 64'(a[2]) * a[4];
      cof[7] = 64'(a[2]) * a[3] - 64'(a[0]) * a[5];
      cof[8] = 64'(a[0]) * a[4] - 64'(a[1]) * a[3];
      det = 128'(cof[0]) * a[0] + 128'(cof[1]) * a[1] + 128'(cof[2]) * a[2];
      if (det == 0) begin
         res.singular = 1'b1;
         return res;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            num = 128'(cof[j*3+i]) <<< (2 * FRAC);
            quo = num / det;
            if (quo > 128'sd2147483647) begin
               quo = 128'sd2147483647;
               res.saturated = 1'b1;
            end else if (quo < -128'sd2147483648) begin
               quo = -128'sd2147483648;
               res.saturated = 1'b1;
            end
            res.entries[(i*3+j)*32 +: 32] = quo[31:0];
         end
      end
      return res;
   endfunction

   function automatic logic [31:0] random_entry();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
         2: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3: return 32'($signed($urandom_range(0, 8)) - 4) << FRAC;
         default: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      endcase
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_rows(int d[9]);
      logic [REQ_DATA_W-1:0] m;
      for (int k = 0; k < 9; k++) m[k*32 +: 32] = 32'(d[k]);
      return m;
   endfunction

   // Fill the stimulus queue: directed corner matrices, then random ones
   initial begin
      logic [REQ_DATA_W-1:0] m;
      int one;
      one = 1 << FRAC;
      pending_matrices.push_back(pack_rows('{one, 0, 0, 0, one, 0, 0, 0, one}));
      pending_matrices.push_back(pack_rows('{2*one, 0, 0, 0, -4*one, 0, 0, 0, one/2}));
      pending_matrices.push_back(pack_rows('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
      pending_matrices.push_back(pack_rows('{one, 2*one, 3*one, 2*one, 4*one, 6*one,
                                             one, 0, one}));
      pending_matrices.push_back(pack_rows('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
      pending_matrices.push_back(pack_rows('{-1, 0, 0, 0, 1, 0, 0, 0, -1}));
      pending_matrices.push_back({9{32'h7FFF_FFFF}});
      pending_matrices.push_back({9{32'h8000_0000}});
      pending_matrices.push_back(pack_rows('{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0,
                                             0, 0, 32'h8000_0000}));
      pending_matrices.push_back(pack_rows('{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0,
                                             0, 0, 32'h7FFF_FFFF}));
      pending_matrices.push_back(pack_rows('{32'h7FFF_FFFF, 32'h8000_0000, 0,
                                             32'h8000_0000, 32'h7FFF_FFFF, 0,
                                             0, 0, one}));
      pending_matrices.push_back(pack_rows('{0, one, 0, 0, 0, one, one, 0, 0}));
      pending_matrices.push_back(pack_rows('{one, 2*one, 3*one, 0, one, 4*one,
                                             5*one, 6*one, 0}));
      pending_matrices.push_back(pack_rows('{3, -7, 11, 5, 2, -9, -1, 4, 6}));
      for (int n = 0; n < N_RANDOM; n++) begin
         for (int k = 0; k < 9; k++) m[k*32 +: 32] = random_entry();
         // Some singular matrices: repeat or zero a row
         case ($urandom_range(0, 9))
            0: m[191:96] = m[95:0];
            1: m[287:192] = '0;
            default: ;
         endcase
         pending_matrices.push_back(m);
      end
   end

   // Cycle counter; it also releases reset
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle == 2) reset <= 1'b0;
   end

   // Drive matrices in bursts with random gaps; pause once to drain the pipeline
   int burst_left = 0;
   int gap_left = 0;
   int sent = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_inverses.push_back(predict_inverse(req_tdata));
            sent <= sent + 1;
         end
         if (req_tvalid && !req_tready) begin
            // hold the current transaction
         end else if (sent == 400 && !paused_once) begin
            hold_sender <= 1'b1;
            paused_once <= 1'b1;
            req_tvalid <= 1'b0;
         end else if (hold_sender) begin
            if (expected_inverses.size() == 0) hold_sender <= 1'b0;
            req_tvalid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_matrices.size() > 0) begin
            req_tdata <= pending_matrices.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // Receiver backpressure: alternate free-flowing and stalling phases
   always @(posedge clock) begin
      if (cycle % 512 < 128) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      inverse_type got;
      inverse_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.entries = rsp_tdata;
         got.singular = rsp_tuser[USER_SINGULAR];
         got.saturated = rsp_tuser[USER_SATURATED];
         if (expected_inverses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction: %h", rsp_tdata);
         end else begin
            want = expected_inverses.pop_front();
            checked++;
            if (want.singular) singular_seen++;
            if (want.saturated) saturated_seen++;
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d mismatch: singular %b/%b saturated %b/%b",
                           checked, want.singular, got.singular, want.saturated,
                           got.saturated);
                  for (int k = 0; k < 9; k++)
                     if (want.entries[k*32 +: 32] != got.entries[k*32 +: 32])
                        $display("  r%0d%0d expected %h got %h", k / 3, k % 3,
                                 want.entries[k*32 +: 32], got.entries[k*32 +: 32]);
               end
            end
         end
      end
   end

   // Wait for the drain, then report
   initial begin
      wait (stimulus_done && expected_inverses.size() == 0);
      repeat (2 * LATENCY) @(posedge clock);
      mismatches += expected_inverses.size();
      $display("checked %0d inverses, %0d singular, %0d with clamped entries",
               checked, singular_seen, saturated_seen);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // Give up on a hung pipeline
   always @(posedge clock) begin
      if (cycle == CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_inverses.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule

`default_nettype wire
